// File: design/sorted_deadline_timer_queue_core_macros.svh
// Assertion macros used by the timer queue RTL
`ifndef SORTED_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define SDTQ_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define SDTQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sdtq_pkg.sv
package sdtq_pkg;

	// Table geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Time arithmetic
	localparam int DL_W      = 49;
	localparam int NUM_W     = 41;
	localparam logic [NUM_W-1:0] US_PER_MS  = NUM_W'(1000);
	localparam logic [NUM_W-1:0] ROUND_UP   = NUM_W'(999);
	localparam logic [DL_W-1:0]  MAX_WAIT_US = DL_W'(64'd2147483647000);

	// Millisecond divider: split the rounded wait at bit SPLIT_W and divide each
	// part by one thousand with a reciprocal multiply and a shift
	localparam int SPLIT_W   = 20;
	localparam int HI_W      = NUM_W - SPLIT_W;
	localparam int REM_W     = 10;
	localparam int LO_W      = REM_W + SPLIT_W;
	localparam int QH_W      = 12;
	localparam int QL_W      = SPLIT_W;
	localparam int RCP_HI_W  = 22;
	localparam int RCP_LO_W  = 31;
	localparam int RCP_HI_SH = HI_W + REM_W;
	localparam int RCP_LO_SH = LO_W + REM_W;
	localparam int PROD_HI_W = HI_W + RCP_HI_W;
	localparam int PROD_LO_W = LO_W + RCP_LO_W;
	localparam logic [RCP_HI_W-1:0] RCP_HI = RCP_HI_W'(2147484);
	localparam logic [RCP_LO_W-1:0] RCP_LO = RCP_LO_W'(1099511628);
	localparam logic [HI_W-1:0]     MS_DIV = HI_W'(1000);

	// Result kinds
	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;
	localparam logic [1:0] KIND_RUN   = 2'd3;

	// Command codes
	localparam logic CMD_SCHEDULE = 1'b0;
	localparam logic CMD_RUN      = 1'b1;

	// Entry write selects
	localparam logic [1:0] WR_NONE   = 2'd0;
	localparam logic [1:0] WR_COPY_W = 2'd1;
	localparam logic [1:0] WR_COPY_R = 2'd2;
	localparam logic [1:0] WR_NEW_R  = 2'd3;

	typedef struct packed {
		logic               command;
		logic [7:0]         handler_id;
		logic [15:0]        context_tag;
		logic signed [31:0] delay_ms;
		logic [47:0]        now_us;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         fired_handler;
		logic [15:0]        fired_context;
		logic signed [31:0] next_delay_ms;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [7:0]      handler;
		logic [15:0]     ctx;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic       load;
		logic       rd_fwd;
		logic       rd_back;
		logic [1:0] wr_op;
		logic       r_inc;
		logic       r_dec;
		logic       r_from_cnt;
		logic       w_inc;
		logic       cnt_from_w;
		logic       cnt_inc;
		logic       cap_head;
		logic       div_start;
		logic       emit;
		logic [1:0] emit_kind;
	} cmd_t;

	typedef struct packed {
		logic command;
		logic neg;
		logic r_eq_cnt;
		logic r_zero;
		logic w_zero;
		logic cnt_full;
		logic cnt_zero;
		logic match;
		logic expired;
		logic later;
		logic out_free;
		logic div_busy;
	} stat_t;

endpackage

// File: design/sorted_deadline_timer_queue_core.sv
// Sorted deadline timer queue. Keeps up to 32 timers ordered by deadline (us) in one
// entry RAM. A schedule item (command 0) removes every timer with the same handler id
// and context tag, then, unless delay_ms is negative, inserts a new timer at
// now_us + delay_ms*1000 behind any equal deadlines, answering one item of kind 1, or
// kind 2 when the table is still full. A run item (command 1) gives one kind 0 item per
// expired timer in deadline order, then one kind 3 item with the rounded-up wait in ms
// (saturated at 2^31-1, or -1 when empty). Items are taken one at a time; each one
// walks the table entries through the RAM's single registered read port, and a run
// that leaves timers uses the three-step reciprocal divider for the ms wait (no steps
// when the wait saturates). The result side can stall the walk. An output register
// lets the next item be taken while the last result waits.
`include "sorted_deadline_timer_queue_core_macros.svh"

module sorted_deadline_timer_queue_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  sdtq_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output sdtq_pkg::out_item_t rsp
);

	sdtq_pkg::cmd_t  cmd;
	sdtq_pkg::stat_t stat;
	logic            fire_emit;
	logic            last_emit;

	sdtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sdtq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	assign fire_emit = cmd.emit && (cmd.emit_kind == sdtq_pkg::KIND_FIRED);
	assign last_emit = cmd.emit && (cmd.emit_kind != sdtq_pkg::KIND_FIRED);

	// Never grow a full table
	`SDTQ_ASSERT_IMPL(a_no_overfill, clk, arst_n, stat.cnt_full, !cmd.cnt_inc, "insert into full table")
	// Fire only timers that have expired
	`SDTQ_ASSERT_IMPL(a_fire_expired, clk, arst_n, fire_emit, stat.expired, "fired a pending timer")
	// A final result frees the input side
	`SDTQ_ASSERT_NEXT(a_ready_after_last, clk, arst_n, last_emit, !req_stall, "input held after last")

endmodule

// File: design/sdtq_ram.sv
module sdtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/sdtq_div.sv
module sdtq_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sdtq_pkg::DL_W-1:0] diff,
	output logic                      busy,
	output logic [30:0]               quot
);

	localparam logic [1:0] STEP_HI  = 2'd0;
	localparam logic [1:0] STEP_REM = 2'd1;
	localparam logic [1:0] STEP_LO  = 2'd2;

	logic [sdtq_pkg::NUM_W-1:0]     num_q;
	logic                           sat_q;
	logic [sdtq_pkg::QH_W-1:0]      qh_q;
	logic [sdtq_pkg::LO_W-1:0]      lo_num_q;
	logic [sdtq_pkg::QL_W-1:0]      ql_q;
	logic [1:0]                     step_q;
	logic                           busy_q;
	logic                           sat;
	logic [sdtq_pkg::HI_W-1:0]      num_hi;
	logic [sdtq_pkg::HI_W-1:0]      rem_hi;
	logic [sdtq_pkg::PROD_HI_W-1:0] prod_hi;
	logic [sdtq_pkg::PROD_LO_W-1:0] prod_lo;

	assign sat     = diff > sdtq_pkg::MAX_WAIT_US;
	assign num_hi  = num_q[sdtq_pkg::NUM_W-1:sdtq_pkg::SPLIT_W];
	assign prod_hi = sdtq_pkg::PROD_HI_W'(num_hi) *
	                 sdtq_pkg::PROD_HI_W'(sdtq_pkg::RCP_HI);
	assign rem_hi  = num_hi - sdtq_pkg::HI_W'(qh_q) * sdtq_pkg::MS_DIV;
	assign prod_lo = sdtq_pkg::PROD_LO_W'(lo_num_q) *
	                 sdtq_pkg::PROD_LO_W'(sdtq_pkg::RCP_LO);
	assign busy    = busy_q;
	assign quot    = sat_q ? 31'h7FFF_FFFF : {qh_q[sdtq_pkg::QH_W-2:0], ql_q};

	// Control: three steps per division, none when the wait saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_HI;
		end else if (start) begin
			busy_q <= !sat;
			step_q <= STEP_HI;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_LO) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: round up, divide the high part, fold its remainder into the low part, divide the low part
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= diff[sdtq_pkg::NUM_W-1:0] + sdtq_pkg::ROUND_UP;
			sat_q <= sat;
		end else if (busy_q) begin
			unique case (step_q)
				STEP_HI: begin
					qh_q <= prod_hi[sdtq_pkg::PROD_HI_W-1:sdtq_pkg::RCP_HI_SH];
				end
				STEP_REM: begin
					lo_num_q <= {rem_hi[sdtq_pkg::REM_W-1:0],
					             num_q[sdtq_pkg::SPLIT_W-1:0]};
				end
				default: begin
					ql_q <= prod_lo[sdtq_pkg::RCP_LO_SH+sdtq_pkg::QL_W-1:sdtq_pkg::RCP_LO_SH];
				end
			endcase
		end
	end

endmodule

// File: design/sdtq_ctrl.sv
module sdtq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sdtq_pkg::stat_t stat,
	output sdtq_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_CRD   = 4'd2;
	localparam logic [3:0] S_CPR   = 4'd3;
	localparam logic [3:0] S_CDEC  = 4'd4;
	localparam logic [3:0] S_IRD   = 4'd5;
	localparam logic [3:0] S_IPR   = 4'd6;
	localparam logic [3:0] S_IWR   = 4'd7;
	localparam logic [3:0] S_RRD   = 4'd8;
	localparam logic [3:0] S_RPR   = 4'd9;
	localparam logic [3:0] S_RFIN  = 4'd10;
	localparam logic [3:0] S_RDIV  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_stall = state_q != S_IDLE;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the compaction, insertion and firing passes
	always_comb begin
		cmd       = '0;
		cmd.wr_op = sdtq_pkg::WR_NONE;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				state_d = (stat.command == sdtq_pkg::CMD_RUN) ? S_RRD : S_CRD;
			end
			S_CRD: begin
				if (stat.r_eq_cnt) begin
					cmd.cnt_from_w = 1'b1;
					state_d        = S_CDEC;
				end else begin
					cmd.rd_fwd = 1'b1;
					state_d    = S_CPR;
				end
			end
			S_CPR: begin
				// drop matching entries, pack the rest down
				if (!stat.match) begin
					cmd.wr_op = sdtq_pkg::WR_COPY_W;
					cmd.w_inc = 1'b1;
				end
				cmd.r_inc = 1'b1;
				state_d   = S_CRD;
			end
			S_CDEC: begin
				priority if (stat.neg) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = sdtq_pkg::KIND_DONE;
						state_d       = S_IDLE;
					end
				end else if (stat.cnt_full) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = sdtq_pkg::KIND_FULL;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.r_from_cnt = 1'b1;
					state_d        = S_IRD;
				end
			end
			S_IRD: begin
				if (stat.r_zero) begin
					state_d = S_IWR;
				end else begin
					cmd.rd_back = 1'b1;
					state_d     = S_IPR;
				end
			end
			S_IPR: begin
				// move later entries up one slot
				if (stat.later) begin
					cmd.wr_op = sdtq_pkg::WR_COPY_R;
					cmd.r_dec = 1'b1;
					state_d   = S_IRD;
				end else begin
					state_d = S_IWR;
				end
			end
			S_IWR: begin
				if (stat.out_free) begin
					cmd.wr_op     = sdtq_pkg::WR_NEW_R;
					cmd.cnt_inc   = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = sdtq_pkg::KIND_DONE;
					state_d       = S_IDLE;
				end
			end
			S_RRD: begin
				if (stat.r_eq_cnt) begin
					cmd.cnt_from_w = 1'b1;
					state_d        = S_RFIN;
				end else begin
					cmd.rd_fwd = 1'b1;
					state_d    = S_RPR;
				end
			end
			S_RPR: begin
				// fire expired entries, pack the rest down
				if (stat.expired) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = sdtq_pkg::KIND_FIRED;
						cmd.r_inc     = 1'b1;
						state_d       = S_RRD;
					end
				end else begin
					cmd.wr_op    = sdtq_pkg::WR_COPY_W;
					cmd.w_inc    = 1'b1;
					cmd.r_inc    = 1'b1;
					cmd.cap_head = stat.w_zero;
					state_d      = S_RRD;
				end
			end
			S_RFIN: begin
				if (stat.cnt_zero) begin
					if (stat.out_free) begin
						cmd.emit      = 1'b1;
						cmd.emit_kind = sdtq_pkg::KIND_RUN;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_RDIV;
				end
			end
			S_RDIV: begin
				if (!stat.div_busy && stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = sdtq_pkg::KIND_RUN;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: design/sdtq_dp.sv
module sdtq_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdtq_pkg::in_item_t   req,
	input  sdtq_pkg::cmd_t       cmd,
	output sdtq_pkg::stat_t      stat,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output sdtq_pkg::out_item_t  rsp
);

	sdtq_pkg::in_item_t          in_q;
	logic [sdtq_pkg::NUM_W-1:0]  prod_q;
	logic [sdtq_pkg::CNT_W-1:0]  r_q;
	logic [sdtq_pkg::CNT_W-1:0]  w_q;
	logic [sdtq_pkg::CNT_W-1:0]  cnt_q;
	logic [sdtq_pkg::DL_W-1:0]   head_q;
	logic                        rsp_valid_q;
	sdtq_pkg::out_item_t         rsp_q;

	logic [sdtq_pkg::DL_W-1:0]    dl;
	logic [sdtq_pkg::DL_W-1:0]    now_ext;
	logic [sdtq_pkg::ENTRY_W-1:0] rd_data;
	sdtq_pkg::entry_t             rd_ent;
	sdtq_pkg::entry_t             new_ent;
	logic                         wr_en;
	logic [sdtq_pkg::IDX_W-1:0]   wr_addr;
	sdtq_pkg::entry_t             wr_ent;
	logic                         rd_en;
	logic [sdtq_pkg::IDX_W-1:0]   rd_addr;
	logic [sdtq_pkg::CNT_W-1:0]   r_less;
	logic                         div_busy;
	logic [30:0]                  div_quot;
	sdtq_pkg::out_item_t          rsp_d;

	// Capture the item and scale its delay to microseconds; capture the head deadline on a run
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q   <= req;
			prod_q <= sdtq_pkg::NUM_W'(req.delay_ms[30:0]) * sdtq_pkg::US_PER_MS;
		end
		if (cmd.cap_head) begin
			head_q <= rd_ent.deadline;
		end
	end

	assign now_ext = sdtq_pkg::DL_W'(in_q.now_us);
	assign dl      = now_ext + sdtq_pkg::DL_W'(prod_q);

	// Walk indexes and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			w_q   <= '0;
			cnt_q <= '0;
		end else begin
			priority if (cmd.load) begin
				r_q <= '0;
			end else if (cmd.r_inc) begin
				r_q <= r_q + 1'b1;
			end else if (cmd.r_dec) begin
				r_q <= r_less;
			end else if (cmd.r_from_cnt) begin
				r_q <= cnt_q;
			end
			if (cmd.load) begin
				w_q <= '0;
			end else if (cmd.w_inc) begin
				w_q <= w_q + 1'b1;
			end
			if (cmd.cnt_from_w) begin
				cnt_q <= w_q;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign r_less = r_q - 1'b1;

	// Entry table
	assign new_ent.deadline = dl;
	assign new_ent.handler  = in_q.handler_id;
	assign new_ent.ctx      = in_q.context_tag;

	assign rd_en   = cmd.rd_fwd || cmd.rd_back;
	assign rd_addr = cmd.rd_back ? r_less[sdtq_pkg::IDX_W-1:0] : r_q[sdtq_pkg::IDX_W-1:0];
	assign rd_ent  = sdtq_pkg::entry_t'(rd_data);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = r_q[sdtq_pkg::IDX_W-1:0];
		wr_ent  = rd_ent;
		unique case (cmd.wr_op)
			sdtq_pkg::WR_NONE: begin
				wr_en = 1'b0;
			end
			sdtq_pkg::WR_COPY_W: begin
				wr_en   = 1'b1;
				wr_addr = w_q[sdtq_pkg::IDX_W-1:0];
			end
			sdtq_pkg::WR_COPY_R: begin
				wr_en = 1'b1;
			end
			sdtq_pkg::WR_NEW_R: begin
				wr_en  = 1'b1;
				wr_ent = new_ent;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	sdtq_ram #(
		.WIDTH(sdtq_pkg::ENTRY_W),
		.DEPTH(sdtq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Millisecond wait until the head deadline
	sdtq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.diff  (head_q - now_ext),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	// Status toward the controller
	assign stat.command  = in_q.command;
	assign stat.neg      = in_q.delay_ms[31];
	assign stat.r_eq_cnt = r_q == cnt_q;
	assign stat.r_zero   = r_q == '0;
	assign stat.w_zero   = w_q == '0;
	assign stat.cnt_full = cnt_q == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_DEPTH);
	assign stat.cnt_zero = cnt_q == '0;
	assign stat.match    = (rd_ent.handler == in_q.handler_id) &&
	                       (rd_ent.ctx == in_q.context_tag);
	assign stat.expired  = rd_ent.deadline <= now_ext;
	assign stat.later    = rd_ent.deadline > dl;
	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign stat.div_busy = div_busy;

	// Build the result item
	always_comb begin
		rsp_d = '0;
		unique case (cmd.emit_kind)
			sdtq_pkg::KIND_FIRED: begin
				rsp_d.kind          = sdtq_pkg::KIND_FIRED;
				rsp_d.fired_handler = rd_ent.handler;
				rsp_d.fired_context = rd_ent.ctx;
			end
			sdtq_pkg::KIND_DONE: begin
				rsp_d.kind = sdtq_pkg::KIND_DONE;
				rsp_d.last = 1'b1;
			end
			sdtq_pkg::KIND_FULL: begin
				rsp_d.kind = sdtq_pkg::KIND_FULL;
				rsp_d.last = 1'b1;
			end
			sdtq_pkg::KIND_RUN: begin
				rsp_d.kind          = sdtq_pkg::KIND_RUN;
				rsp_d.next_delay_ms = stat.cnt_zero ? '1 : {1'b0, div_quot};
				rsp_d.last          = 1'b1;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: test/tb_sorted_deadline_timer_queue_core.sv
module tb_sorted_deadline_timer_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          TAIL_CYCLES = 200;
	localparam logic [47:0] MAX_NOW     = 48'hFFFF_FFFF_FFFF;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	sdtq_pkg::in_item_t  req;
	logic                rsp_valid;
	logic                rsp_stall;
	sdtq_pkg::out_item_t rsp;

	// Timer table as the testbench sees it
	logic [48:0] timer_deadline [sdtq_pkg::QUEUE_DEPTH];
	logic [7:0]  timer_handler [sdtq_pkg::QUEUE_DEPTH];
	logic [15:0] timer_ctx [sdtq_pkg::QUEUE_DEPTH];
	int          timer_count = 0;

	sdtq_pkg::out_item_t awaited_rsp [$];
	sdtq_pkg::out_item_t want_rsp;
	int                  mismatches = 0;
	int                  cycle_count = 0;
	int                  gap_max;
	int                  rsp_hold_left;
	int                  long_hold_left;
	logic [47:0]         clock_us;

	sorted_deadline_timer_queue_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Work out the results of one accepted item and update the timer table
	task automatic apply_timer_cmd(input sdtq_pkg::in_item_t it);
		int                  keep;
		int                  pos;
		int                  nfired;
		logic [63:0]         sum;
		logic [48:0]         dl;
		logic [63:0]         wait_us;
		logic [63:0]         wait_ms;
		sdtq_pkg::out_item_t r;
		if (it.command == sdtq_pkg::CMD_SCHEDULE) begin
			// Drop every timer with the same handler and context
			keep = 0;
			for (int i = 0; i < timer_count; i++) begin
				if (!(timer_handler[i] == it.handler_id && timer_ctx[i] == it.context_tag)) begin
					timer_deadline[keep] = timer_deadline[i];
					timer_handler[keep]  = timer_handler[i];
					timer_ctx[keep]      = timer_ctx[i];
					keep++;
				end
			end
			timer_count = keep;
			r = '0;
			r.kind = sdtq_pkg::KIND_DONE;
			r.last = 1'b1;
			if (it.delay_ms[31]) begin
				awaited_rsp.push_back(r);
			end else if (timer_count >= sdtq_pkg::QUEUE_DEPTH) begin
				r.kind = sdtq_pkg::KIND_FULL;
				awaited_rsp.push_back(r);
			end else begin
				sum = 64'(it.now_us) + 64'(it.delay_ms[30:0]) * 64'd1000;
				dl  = sum[48:0];
				// Insert behind all equal or earlier deadlines
				pos = 0;
				while (pos < timer_count && timer_deadline[pos] <= dl)
					pos++;
				for (int i = timer_count; i > pos; i--) begin
					timer_deadline[i] = timer_deadline[i-1];
					timer_handler[i]  = timer_handler[i-1];
					timer_ctx[i]      = timer_ctx[i-1];
				end
				timer_deadline[pos] = dl;
				timer_handler[pos]  = it.handler_id;
				timer_ctx[pos]      = it.context_tag;
				timer_count++;
				awaited_rsp.push_back(r);
			end
		end else begin
			// Fire expired timers in deadline order
			nfired = 0;
			while (nfired < timer_count && timer_deadline[nfired] <= {1'b0, it.now_us}) begin
				r = '0;
				r.kind          = sdtq_pkg::KIND_FIRED;
				r.fired_handler = timer_handler[nfired];
				r.fired_context = timer_ctx[nfired];
				awaited_rsp.push_back(r);
				nfired++;
			end
			for (int i = nfired; i < timer_count; i++) begin
				timer_deadline[i-nfired] = timer_deadline[i];
				timer_handler[i-nfired]  = timer_handler[i];
				timer_ctx[i-nfired]      = timer_ctx[i];
			end
			timer_count -= nfired;
			r = '0;
			r.kind = sdtq_pkg::KIND_RUN;
			r.last = 1'b1;
			if (timer_count == 0) begin
				r.next_delay_ms = -32'sd1;
			end else begin
				// Round the wait up to whole ms and saturate
				wait_us = 64'(timer_deadline[0]) - 64'(it.now_us);
				wait_ms = (wait_us + 64'd999) / 64'd1000;
				r.next_delay_ms = (wait_ms > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : wait_ms[31:0];
			end
			awaited_rsp.push_back(r);
		end
	endtask

	// Predict on every accepted request item
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			apply_timer_cmd(req);
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				$display("%0t: result expected none actual %p", $time, rsp);
			end else begin
				want_rsp = awaited_rsp.pop_front();
				check_field("kind", 32'(want_rsp.kind), 32'(rsp.kind));
				check_field("fired_handler", 32'(want_rsp.fired_handler), 32'(rsp.fired_handler));
				check_field("fired_context", 32'(want_rsp.fired_context), 32'(rsp.fired_context));
				check_field("next_delay_ms", want_rsp.next_delay_ms, rsp.next_delay_ms);
				check_field("last", 32'(want_rsp.last), 32'(rsp.last));
			end
			rsp_hold_left = $urandom_range(0, gap_max);
		end
	end

	// Hold off results: long hold first, then the per-item wait
	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			rsp_stall = 1'b1;
			long_hold_left--;
		end else if (rsp_hold_left > 0) begin
			rsp_stall = 1'b1;
			rsp_hold_left--;
		end else begin
			rsp_stall = 1'b0;
		end
	end

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input sdtq_pkg::in_item_t it);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = it;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop offering and wait for every predicted result
	task automatic wait_for_drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic sdtq_pkg::in_item_t sched_item(input logic [7:0] h,
			input logic [15:0] c, input logic signed [31:0] d, input logic [47:0] now);
		sdtq_pkg::in_item_t it;
		it.command     = sdtq_pkg::CMD_SCHEDULE;
		it.handler_id  = h;
		it.context_tag = c;
		it.delay_ms    = d;
		it.now_us      = now;
		return it;
	endfunction

	// Key and delay are ignored on a run, so fill them with noise
	function automatic sdtq_pkg::in_item_t run_item(input logic [47:0] now);
		sdtq_pkg::in_item_t it;
		it.command     = sdtq_pkg::CMD_RUN;
		it.handler_id  = 8'($urandom);
		it.context_tag = 16'($urandom);
		it.delay_ms    = $urandom;
		it.now_us      = now;
		return it;
	endfunction

	task automatic test_empty_run();
		send_item(run_item(48'd0));
		send_item(run_item(MAX_NOW));
	endtask

	// Equal deadlines keep arrival order, partial key match survives, rounding up
	task automatic test_fire_order();
		wait_for_drain();
		send_item(sched_item(8'hFF, 16'hFFFF, 0, 48'd0));
		send_item(sched_item(8'h00, 16'h0000, 0, 48'd0));
		send_item(sched_item(8'hFF, 16'h0000, 1, 48'd0));
		send_item(sched_item(8'hFF, 16'hFFFF, 0, 48'd0));
		send_item(run_item(48'd0));
		send_item(run_item(48'd1));
		send_item(run_item(48'd999));
		send_item(run_item(48'd1000));
	endtask

	// Cancel hits, cancel misses, reschedule replaces
	task automatic test_cancel();
		wait_for_drain();
		send_item(sched_item(8'h05, 16'h0009, 10, 48'd1000));
		send_item(sched_item(8'h05, 16'h0009, -1, 48'd1000));
		send_item(sched_item(8'h05, 16'h0009, 32'h8000_0000, 48'd1000));
		send_item(sched_item(8'h05, 16'h0009, 20, 48'd1000));
		send_item(sched_item(8'h05, 16'h0009, 30, 48'd1000));
		send_item(run_item(48'd1000));
		send_item(sched_item(8'h05, 16'h0009, -7, 48'd0));
		send_item(run_item(48'd2000));
	endtask

	// Longest delay from the latest time, then a wait that saturates
	task automatic test_large_wait();
		wait_for_drain();
		send_item(sched_item(8'h80, 16'h8000, 32'h7FFF_FFFF, MAX_NOW));
		send_item(run_item(MAX_NOW));
		send_item(run_item(48'd0));
		send_item(sched_item(8'h80, 16'h8000, -1, 48'd0));
		send_item(run_item(48'd0));
	endtask

	// Fill the table under a long result hold, hit full, then fire everything at once
	task automatic test_table_full();
		logic [15:0] ctx_of [sdtq_pkg::QUEUE_DEPTH];
		logic [47:0] base;
		wait_for_drain();
		send_item(run_item(MAX_NOW));
		long_hold_left = 400;
		base = 48'd1_000_000;
		for (int i = 0; i < sdtq_pkg::QUEUE_DEPTH; i++) begin
			ctx_of[i] = 16'($urandom);
			send_item(sched_item(8'(i), ctx_of[i], $urandom_range(0, 5000), base));
		end
		send_item(sched_item(8'd200, 16'h1234, 7, base));
		send_item(sched_item(8'd3, ctx_of[3], 4000, base));
		send_item(sched_item(8'd201, 16'h4321, 9, base));
		send_item(sched_item(8'd5, ctx_of[5], -5, base));
		send_item(sched_item(8'd202, 16'hBEEF, 1, base));
		send_item(run_item(base + 48'd6_000_000));
	endtask

	// Mostly a moving clock with a small key pool, plus raw noise
	task automatic test_random();
		logic [7:0]         pool_h [12];
		logic [15:0]        pool_c [12];
		int                 pick;
		int                 sub;
		int                 k;
		logic signed [31:0] d;
		sdtq_pkg::in_item_t it;
		wait_for_drain();
		for (int i = 0; i < 12; i++) begin
			pool_h[i] = 8'($urandom);
			pool_c[i] = 16'($urandom);
		end
		clock_us = 48'd10_000_000;
		for (int n = 0; n < 170; n++) begin
			// Alternate between idling and back-to-back stretches
			if (n % 40 == 39)
				gap_max = (gap_max == 0) ? 13 : 0;
			if (n == 85)
				wait_for_drain();
			clock_us += 48'($urandom_range(0, 20_000));
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				sub = $urandom_range(0, 99);
				if (sub < 65)
					d = $urandom_range(0, 300);
				else if (sub < 80)
					d = {1'b1, 31'($urandom)};
				else if (sub < 95)
					d = {1'b0, 31'($urandom)};
				else
					d = 0;
				k = $urandom_range(0, 11);
				send_item(sched_item(pool_h[k], pool_c[k], d, clock_us));
			end else if (pick < 90) begin
				send_item(run_item(clock_us));
			end else begin
				it.command     = 1'($urandom);
				it.handler_id  = 8'($urandom);
				it.context_tag = 16'($urandom);
				it.delay_ms    = $urandom;
				it.now_us      = {16'($urandom), $urandom};
				send_item(it);
			end
		end
		gap_max = 13;
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		rsp_stall      = 1'b0;
		gap_max        = 13;
		rsp_hold_left  = 0;
		long_hold_left = 0;
		clock_us       = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_run();
		test_fire_order();
		test_cancel();
		test_large_wait();
		test_table_full();
		test_random();

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/sdtq_pkg.sv
design/sdtq_ram.sv
design/sdtq_div.sv
design/sdtq_ctrl.sv
design/sdtq_dp.sv
design/sorted_deadline_timer_queue_core.sv
test/tb_sorted_deadline_timer_queue_core.sv
